[src/ilir_pkg.sv]
// shared types, codes and field widths of the indexed list
package ilir_pkg;

  // default geometry
  localparam int unsigned DEPTH_DEF      = 16;
  localparam int unsigned ELEM_WIDTH_DEF = 32;

  // fixed field widths of the request and result transactions
  localparam int unsigned OP_W     = 3;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned VAL_W    = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 5;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 3'd0,
    OP_REMOVE = 3'd1,
    OP_SET    = 3'd2,
    OP_GET    = 3'd3,
    OP_RESIZE = 3'd4,
    OP_CLEAR  = 3'd5
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             ins;   // open a gap at pos
    logic             rem;   // close the gap at pos
    logic             wr;    // write the value at pos
    logic [POS_W-1:0] pos;
  } cell_ctrl_t;

endpackage

[src/ilir_if.sv]
// request and result channels of the indexed list
interface ilir_req_if;
  logic                          valid;
  logic                          ready;
  logic [ilir_pkg::OP_W-1:0]     opcode;
  logic [ilir_pkg::POS_W-1:0]    position;
  logic [ilir_pkg::VAL_W-1:0]    value;

  modport source (output valid, opcode, position, value, input ready);
  modport sink   (input valid, opcode, position, value, output ready);
endinterface

interface ilir_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [ilir_pkg::STATUS_W-1:0] status;
  logic [ilir_pkg::VAL_W-1:0]    read_value;
  logic [ilir_pkg::LEN_W-1:0]    length;

  modport source (output valid, status, read_value, length, input ready);
  modport sink   (input valid, status, read_value, length, output ready);
endinterface

[src/ilir_cell.sv]
// one storage cell of the list, shifting with its neighbours
module ilir_cell #(
  parameter int unsigned DEPTH      = ilir_pkg::DEPTH_DEF,
  parameter int unsigned ELEM_WIDTH = ilir_pkg::ELEM_WIDTH_DEF,
  parameter int unsigned IDX        = 0,
  localparam int unsigned CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ilir_pkg::cell_ctrl_t    ctrl_i,
  input  logic [CNT_W-1:0]        count_i,
  input  logic [ELEM_WIDTH-1:0]   val_i,
  input  logic [ELEM_WIDTH-1:0]   lower_i,  // data of the cell below
  input  logic [ELEM_WIDTH-1:0]   upper_i,  // data of the cell above
  output logic [ELEM_WIDTH-1:0]   data_o,
  output logic [ELEM_WIDTH-1:0]   rd_o
);
  import ilir_pkg::*;

  logic [ELEM_WIDTH-1:0] data_q, data_d;
  logic                  at_pos;

  assign at_pos = (IDX == int'(ctrl_i.pos));

  // next contents: own write, shift up, shift down or hold
  always_comb begin
    data_d = data_q;
    if (ctrl_i.wr && at_pos) begin
      data_d = val_i;
    end else if (ctrl_i.ins && (IDX > int'(ctrl_i.pos)) && (IDX <= int'(count_i))) begin
      data_d = lower_i;
    end else if (ctrl_i.rem && (IDX >= int'(ctrl_i.pos)) && (IDX + 1 < int'(count_i))) begin
      data_d = upper_i;
    end
  end

  // cell storage, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else begin
      data_q <= data_d;
    end
  end

  assign data_o = data_q;
  // contribution to the read bus, zero unless addressed
  assign rd_o   = at_pos ? data_q : '0;

endmodule

[src/indexed_list_insert_remove.sv]
// Indexed list of DEPTH elements held in a row of cells. Each request transaction
// (insert, remove, set, get, resize, clear) is accepted when valid and ready meet, and its
// result transaction is presented from an output register in the cycle after acceptance,
// so one request per clock is sustained while the result side keeps up. Every cell shifts,
// writes or holds in parallel as the request is accepted; a get is served by OR-ing the
// addressed cell onto a shared read bus. The cells are cleared by reset, so no start-up pass.
module indexed_list_insert_remove #(
  parameter int unsigned DEPTH      = ilir_pkg::DEPTH_DEF,
  parameter int unsigned ELEM_WIDTH = ilir_pkg::ELEM_WIDTH_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ilir_req_if.sink         req_i,
  ilir_rsp_if.source       rsp_o
);
  import ilir_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned XW    = (ELEM_WIDTH > VAL_W) ? ELEM_WIDTH : VAL_W;

  logic [CNT_W-1:0]      count_q, count_d;
  logic                  rsp_valid_q;
  logic [STATUS_W-1:0]   status_q;
  logic [VAL_W-1:0]      rdval_q;
  logic [LEN_W-1:0]      len_q;

  logic                  fire;
  logic [CMP_W-1:0]      pos_x, cnt_x, cnt_next_x;
  logic [XW-1:0]         val_x, rd_x;
  logic [ELEM_WIDTH-1:0] val_e, rd_e;
  status_e               status_d;
  logic                  get_ok;
  cell_ctrl_t            ctrl;

  logic [ELEM_WIDTH-1:0] cell_data [DEPTH];
  logic [ELEM_WIDTH-1:0] cell_rd   [DEPTH];

  assign fire        = req_i.valid && req_i.ready;
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;

  assign pos_x = CMP_W'(req_i.position);
  assign cnt_x = CMP_W'(count_q);
  assign val_x = XW'(req_i.value);
  assign val_e = val_x[ELEM_WIDTH-1:0];

  // request decode: range checks, cell controls and next length
  always_comb begin
    status_d = ST_OK;
    get_ok   = 1'b0;
    count_d  = count_q;
    ctrl     = '{ins: 1'b0, rem: 1'b0, wr: 1'b0, pos: req_i.position};
    case (op_e'(req_i.opcode))
      OP_INSERT: begin
        if (pos_x > cnt_x) begin
          status_d = ST_RANGE;
        end else if (count_q == CNT_W'(DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          ctrl.ins = fire;
          ctrl.wr  = fire;
          count_d  = count_q + CNT_W'(1);
        end
      end
      OP_REMOVE: begin
        if (pos_x >= cnt_x) begin
          status_d = ST_RANGE;
        end else begin
          ctrl.rem = fire;
          count_d  = count_q - CNT_W'(1);
        end
      end
      OP_SET: begin
        if (pos_x >= cnt_x) begin
          status_d = ST_RANGE;
        end else begin
          ctrl.wr = fire;
        end
      end
      OP_GET: begin
        if (pos_x >= cnt_x) begin
          status_d = ST_RANGE;
        end else begin
          get_ok = 1'b1;
        end
      end
      OP_RESIZE: begin
        if (pos_x > CMP_W'(DEPTH)) begin
          status_d = ST_FULL;
        end else begin
          count_d = pos_x[CNT_W-1:0];
        end
      end
      OP_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  // row of cells
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [ELEM_WIDTH-1:0] lower, upper;
    if (g == 0) begin : g_bot
      assign lower = '0;
    end else begin : g_mid_lo
      assign lower = cell_data[g-1];
    end
    if (g == DEPTH - 1) begin : g_top
      assign upper = '0;
    end else begin : g_mid_hi
      assign upper = cell_data[g+1];
    end
    ilir_cell #(
      .DEPTH      (DEPTH),
      .ELEM_WIDTH (ELEM_WIDTH),
      .IDX        (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .val_i   (val_e),
      .lower_i (lower),
      .upper_i (upper),
      .data_o  (cell_data[g]),
      .rd_o    (cell_rd[g])
    );
  end

  // read bus
  always_comb begin
    rd_e = '0;
    for (int i = 0; i < DEPTH; i++) begin
      rd_e = rd_e | cell_rd[i];
    end
  end

  assign rd_x       = get_ok ? XW'(rd_e) : '0;
  assign cnt_next_x = CMP_W'(count_d);

  // length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (fire) begin
      count_q <= count_d;
    end
  end

  // result transaction valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      rsp_valid_q <= req_i.valid;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q <= status_d;
      rdval_q  <= rd_x[VAL_W-1:0];
      len_q    <= cnt_next_x[LEN_W-1:0];
    end
  end

  assign rsp_o.valid      = rsp_valid_q;
  assign rsp_o.status     = status_q;
  assign rsp_o.read_value = rdval_q;
  assign rsp_o.length     = len_q;

`ifndef SYNTHESIS
  logic [CMP_W-1:0] cnt_q_x;
  assign cnt_q_x = CMP_W'(count_q);

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(DEPTH))
    else $error("list length beyond capacity");

  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> rsp_valid_q)
    else $error("accepted request gave no result");

  a_length_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q |-> (len_q == cnt_q_x[LEN_W-1:0]))
    else $error("reported length differs from list length");

  a_fail_keeps_len : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && (status_d != ST_OK)) |=> $stable(count_q))
    else $error("failed request changed the length");
`endif

endmodule

[bench/tb_top.sv]
// self-checking bench for the indexed list: directed and random request transactions
module tb_top;
  import ilir_pkg::*;

  localparam int unsigned DEPTH        = DEPTH_DEF;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned TAIL_ITEMS   = 200;
  localparam int unsigned CYCLE_LIMIT  = 400000;

  // opcodes the block treats as no operation
  localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

  localparam logic [VAL_W-1:0] ALL_ONES = '1;

  typedef struct packed {
    logic [OP_W-1:0]  opcode;
    logic [POS_W-1:0] position;
    logic [VAL_W-1:0] value;
  } list_req_t;

  typedef struct packed {
    status_e          status;
    logic [VAL_W-1:0] read_value;
    logic [LEN_W-1:0] length;
  } list_rsp_t;

  // clock, reset and the signals driven into the block
  logic             clk_i      = 1'b0;
  logic             rst_ni     = 1'b0;
  logic             req_valid  = 1'b0;
  logic [OP_W-1:0]  req_opcode = '0;
  logic [POS_W-1:0] req_pos    = '0;
  logic [VAL_W-1:0] req_value  = '0;
  logic             rsp_ready  = 1'b0;

  // idling state of both sides
  int unsigned src_gap   = 0;
  int unsigned sink_gap  = 0;
  bit          src_calm  = 1'b0;
  bit          sink_calm = 1'b0;

  int unsigned cycle_count = 0;
  int unsigned mismatches  = 0;

  // shadow of the list contents and length
  logic [VAL_W-1:0] list_cells [DEPTH];
  int unsigned      list_len;

  list_req_t req_backlog [$];
  list_rsp_t awaited_results [$];
  list_req_t next_req;

  ilir_req_if req_if ();
  ilir_rsp_if rsp_if ();

  assign req_if.valid    = req_valid;
  assign req_if.opcode   = req_opcode;
  assign req_if.position = req_pos;
  assign req_if.value    = req_value;
  assign rsp_if.ready    = rsp_ready;

  indexed_list_insert_remove dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // apply one request to the shadow list and queue the result it should give
  function automatic void predict_list_op(input list_req_t rq);
    list_rsp_t   res;
    int unsigned p;
    res = '{status: ST_OK, read_value: '0, length: '0};
    p   = 32'(rq.position);
    case (rq.opcode)
      OP_INSERT: begin
        // the range check wins over the full check
        if (p > list_len) begin
          res.status = ST_RANGE;
        end else if (list_len >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          for (int unsigned i = list_len; i > p; i--) list_cells[i] = list_cells[i-1];
          list_cells[p] = rq.value;
          list_len++;
        end
      end
      OP_REMOVE: begin
        // vacated top cell keeps its old contents
        if (p >= list_len) begin
          res.status = ST_RANGE;
        end else begin
          for (int unsigned i = p; i + 1 < list_len; i++) list_cells[i] = list_cells[i+1];
          list_len--;
        end
      end
      OP_SET: begin
        if (p >= list_len) res.status = ST_RANGE;
        else list_cells[p] = rq.value;
      end
      OP_GET: begin
        if (p >= list_len) res.status = ST_RANGE;
        else res.read_value = list_cells[p];
      end
      OP_RESIZE: begin
        // cells beyond the length keep their data either way
        if (p > DEPTH) res.status = ST_FULL;
        else list_len = p;
      end
      OP_CLEAR: begin
        list_len = 0;
      end
      default: begin
      end
    endcase
    res.length = LEN_W'(list_len);
    awaited_results.push_back(res);
  endfunction

  task automatic push_req(input logic [OP_W-1:0] op, input logic [POS_W-1:0] pos,
                          input logic [VAL_W-1:0] val);
    req_backlog.push_back('{opcode: op, position: pos, value: val});
  endtask

  // request driver: holds each transaction until taken, idles in bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
      src_gap   <= 0;
    end else begin
      if (req_valid && req_if.ready) begin
        predict_list_op('{opcode: req_if.opcode, position: req_if.position,
                          value: req_if.value});
      end
      if (!req_valid || req_if.ready) begin
        if (src_gap != 0) begin
          src_gap   <= src_gap - 1;
          req_valid <= 1'b0;
        end else if (req_backlog.size() == 0) begin
          req_valid <= 1'b0;
        end else if (req_backlog.size() > TAIL_ITEMS && !src_calm &&
                     $urandom_range(0, 7) == 0) begin
          src_gap   <= $urandom_range(0, 14);
          req_valid <= 1'b0;
        end else begin
          next_req   = req_backlog.pop_front();
          req_valid  <= 1'b1;
          req_opcode <= next_req.opcode;
          req_pos    <= next_req.position;
          req_value  <= next_req.value;
        end
        if ($urandom_range(0, 99) == 0) src_calm <= !src_calm;
      end
    end
  end

  // result monitor: checks each taken transaction, stalls in bursts
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready <= 1'b0;
      sink_gap  <= 0;
    end else begin
      if (rsp_if.valid && rsp_ready) begin : take_result
        list_rsp_t want;
        if (awaited_results.size() == 0) begin
          $display("%0t: unexpected result: status %0d read_value %h length %0d",
                   $time, rsp_if.status, rsp_if.read_value, rsp_if.length);
          mismatches++;
        end else begin
          want = awaited_results.pop_front();
          if (rsp_if.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $time, want.status, rsp_if.status);
            mismatches++;
          end
          if (rsp_if.read_value !== want.read_value) begin
            $display("%0t: read_value expected %h actual %h",
                     $time, want.read_value, rsp_if.read_value);
            mismatches++;
          end
          if (rsp_if.length !== want.length) begin
            $display("%0t: length expected %0d actual %0d",
                     $time, want.length, rsp_if.length);
            mismatches++;
          end
        end
      end
      if (sink_gap != 0) begin
        sink_gap  <= sink_gap - 1;
        rsp_ready <= 1'b0;
      end else if (req_backlog.size() > TAIL_ITEMS && !sink_calm &&
                   $urandom_range(0, 7) == 0) begin
        sink_gap  <= $urandom_range(0, 14);
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
      if ($urandom_range(0, 99) == 0) sink_calm <= !sink_calm;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    logic [OP_W-1:0]  op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int unsigned      gen_len;
    int unsigned      pick;

    foreach (list_cells[i]) list_cells[i] = '0;
    list_len = 0;

    // empty list: every access is out of range, insert past the end too
    push_req(OP_GET,    5'd0, '0);
    push_req(OP_REMOVE, 5'd0, '0);
    push_req(OP_SET,    5'd0, ALL_ONES);
    push_req(OP_INSERT, 5'd1, ALL_ONES);
    // build a short list: append, front and middle inserts
    push_req(OP_INSERT, 5'd0, ALL_ONES);
    push_req(OP_INSERT, 5'd1, '0);
    push_req(OP_INSERT, 5'd0, 32'h5a5a_a5a5);
    push_req(OP_INSERT, 5'd1, 32'h0000_0001);
    push_req(OP_GET,    5'd0, '0);
    push_req(OP_GET,    5'd3, '0);
    // remove at the front and at the end
    push_req(OP_REMOVE, 5'd0, '0);
    push_req(OP_REMOVE, 5'd2, '0);
    // grow to capacity, exposing stale and never-written cells
    push_req(OP_RESIZE, 5'd16, '0);
    push_req(OP_GET,    5'd15, '0);
    // full list: an insert beyond the length is a range error, other inserts and oversize resizes are full
    push_req(OP_INSERT, 5'd17, ALL_ONES);
    push_req(OP_INSERT, 5'd16, ALL_ONES);
    push_req(OP_INSERT, 5'd0, ALL_ONES);
    push_req(OP_SET,    5'd15, ALL_ONES);
    push_req(OP_GET,    5'd16, '0);
    push_req(OP_RESIZE, 5'd17, '0);
    push_req(OP_RESIZE, 5'd31, '0);
    // shrink by a remove, then regrow to see the stale top cell
    push_req(OP_REMOVE, 5'd7, '0);
    push_req(OP_RESIZE, 5'd16, '0);
    push_req(OP_GET,    5'd15, '0);
    push_req(OP_SPARE_A, 5'd31, ALL_ONES);
    push_req(OP_SPARE_B, 5'd0, '0);
    push_req(OP_CLEAR,  5'd0, '0);
    push_req(OP_RESIZE, 5'd0, '0);
    push_req(OP_GET,    5'd0, '0);

    // random part: positions mostly within the current length
    gen_len = 0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 34)      op = OP_INSERT;
      else if (pick < 54) op = OP_REMOVE;
      else if (pick < 66) op = OP_SET;
      else if (pick < 84) op = OP_GET;
      else if (pick < 91) op = OP_RESIZE;
      else if (pick < 94) op = OP_CLEAR;
      else if (pick < 97) op = OP_SPARE_A;
      else                op = OP_SPARE_B;

      if ($urandom_range(0, 6) == 0) begin
        pos = POS_W'($urandom_range(0, 31));
      end else begin
        case (op)
          OP_INSERT: pos = POS_W'($urandom_range(0, gen_len));
          OP_RESIZE: pos = POS_W'($urandom_range(0, DEPTH));
          default:   pos = (gen_len == 0) ? '0 : POS_W'($urandom_range(0, gen_len - 1));
        endcase
      end

      case ($urandom_range(0, 7))
        0:       val = '0;
        1:       val = ALL_ONES;
        2:       val = VAL_W'(1) << $urandom_range(0, VAL_W - 1);
        3:       val = ~(VAL_W'(1) << $urandom_range(0, VAL_W - 1));
        default: val = $urandom();
      endcase

      push_req(op, pos, val);

      // length only, to steer the positions
      case (op)
        OP_INSERT: if (pos <= gen_len && gen_len < DEPTH) gen_len++;
        OP_REMOVE: if (pos < gen_len) gen_len--;
        OP_RESIZE: if (pos <= DEPTH) gen_len = 32'(pos);
        OP_CLEAR:  gen_len = 0;
        default: begin
        end
      endcase
    end

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (req_backlog.size() != 0 || req_valid || awaited_results.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
src/ilir_pkg.sv
src/ilir_if.sv
src/ilir_cell.sv
src/indexed_list_insert_remove.sv
bench/tb_top.sv
